[rtl/vtd_pkg.sv]
// ----------------------------------------------------------------------------
// vtd_pkg
// Shared types and constants of the video time displacement block: the
// input and result words, the classified operation flags and the queue depth.
// ----------------------------------------------------------------------------
package vtd_pkg;

    // Width and reset value of the frame length register
    localparam int CFG_W = 17;
    localparam logic [CFG_W-1:0] CFG_RESET = 17'h10000;

    // Entries in the queue between classifier and history engine
    localparam int QUEUE_DEPTH = 2;

    // Input word: current frame byte and its time map value
    typedef struct packed {
        logic [7:0] pixel_byte;
        logic [7:0] delay_frames;
    } t_in_word;

    // Result word: delayed byte and the missing-source flag
    typedef struct packed {
        logic [7:0] out_byte;
        logic       source_missing;
    } t_out_word;

    // Classified operation: how the back end forms the result
    typedef struct packed {
        logic       bypass;      // delay zero: answer with the byte itself
        logic       missing;     // no usable source frame: answer with zero
        logic [7:0] pixel_byte;  // byte to store in the history
    } t_op_info;

endpackage

[rtl/vtd_front.sv]
// ----------------------------------------------------------------------------
// vtd_front
// Accepts input words, tracks raster position, ring slot and filled-frame
// count, and turns each word into a history write and read address plus
// the flags that tell the back end how to form the result.
// ----------------------------------------------------------------------------
module vtd_front
    import vtd_pkg::*;
#(
    parameter int HISTORY_FRAMES = 64,
    parameter int FRAME_BYTES    = 65536
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_cfg_we,
    input  logic [CFG_W-1:0]           i_cfg_wdata,
    input  logic                       i_in_valid,
    input  t_in_word                   i_in_word,
    input  logic                       i_q_full,
    output logic                       o_in_stall,
    output logic                       o_push,
    output t_op_info                   o_info,
    output logic [$clog2(HISTORY_FRAMES)+$clog2(FRAME_BYTES)-1:0] o_wr_addr,
    output logic [$clog2(HISTORY_FRAMES)+$clog2(FRAME_BYTES)-1:0] o_rd_addr
);

    localparam int PW = $clog2(FRAME_BYTES);
    localparam int SW = $clog2(HISTORY_FRAMES);
    localparam int FW = $clog2(HISTORY_FRAMES + 1);
    localparam int CW = (PW + 1 > CFG_W) ? PW + 1 : CFG_W;
    localparam int DW = 9;  // holds any delay and any history depth

    logic [CFG_W-1:0] r_cfg;
    logic [PW-1:0]    r_pos,    n_pos;
    logic [SW-1:0]    r_slot,   n_slot;
    logic [FW-1:0]    r_filled, n_filled;

    logic [CW-1:0]    cfg_x;
    logic [PW-1:0]    lenm1;
    logic [PW-1:0]    pos_eff;
    logic             frame_end;
    logic             accept;
    logic [DW-1:0]    delay_x;
    logic [DW-1:0]    slot_x;
    logic [DW-1:0]    src_x;
    logic [SW-1:0]    src_slot;
    logic             in_range;

    // Frame length register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= CFG_RESET;
        end else if (i_cfg_we) begin
            r_cfg <= i_cfg_wdata;
        end
    end

    // Clamp the frame length to one..FRAME_BYTES and keep its last position
    always_comb begin
        cfg_x = CW'(r_cfg);
        if (r_cfg == '0) begin
            lenm1 = '0;
        end else if (cfg_x > CW'(FRAME_BYTES)) begin
            lenm1 = PW'(FRAME_BYTES - 1);
        end else begin
            lenm1 = PW'(cfg_x - CW'(1));
        end
    end

    // Pull the position back into a shortened frame; the last byte ends it
    assign frame_end = (r_pos >= lenm1);
    assign pos_eff   = frame_end ? lenm1 : r_pos;

    // Source slot lies delay frames behind the write slot, modulo the ring
    always_comb begin
        delay_x  = DW'(i_in_word.delay_frames);
        slot_x   = DW'(r_slot);
        in_range = (delay_x < DW'(HISTORY_FRAMES)) && (delay_x <= DW'(r_filled));
        if (slot_x >= delay_x) begin
            src_x = slot_x - delay_x;
        end else begin
            src_x = slot_x + DW'(HISTORY_FRAMES) - delay_x;
        end
        src_slot = src_x[SW-1:0];
    end

    assign o_in_stall = i_q_full;
    assign accept     = i_in_valid && !i_q_full;
    assign o_push     = accept;

    assign o_info.bypass     = (i_in_word.delay_frames == '0);
    assign o_info.missing    = !in_range;
    assign o_info.pixel_byte = i_in_word.pixel_byte;
    assign o_wr_addr         = {r_slot, pos_eff};
    assign o_rd_addr         = {src_slot, pos_eff};

    // Advance position; on frame end wrap it, step the slot, count the frame
    always_comb begin
        n_pos    = r_pos;
        n_slot   = r_slot;
        n_filled = r_filled;
        if (accept) begin
            if (frame_end) begin
                n_pos = '0;
                if (r_slot == SW'(HISTORY_FRAMES - 1)) begin
                    n_slot = '0;
                end else begin
                    n_slot = r_slot + SW'(1);
                end
                if (r_filled != FW'(HISTORY_FRAMES)) begin
                    n_filled = r_filled + FW'(1);
                end
            end else begin
                n_pos = r_pos + PW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos    <= '0;
            r_slot   <= '0;
            r_filled <= '0;
        end else begin
            r_pos    <= n_pos;
            r_slot   <= n_slot;
            r_filled <= n_filled;
        end
    end

endmodule

[rtl/vtd_queue.sv]
// ----------------------------------------------------------------------------
// vtd_queue
// Short first-in first-out queue of classified operations between the
// classifier and the history engine.
// ----------------------------------------------------------------------------
module vtd_queue
    import vtd_pkg::*;
#(
    parameter int WIDTH = 8
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    input  logic             i_pop,
    output logic             o_valid,
    output logic             o_full,
    output logic [WIDTH-1:0] o_data
);

    localparam int QPW = $clog2(QUEUE_DEPTH);
    localparam int QCW = $clog2(QUEUE_DEPTH + 1);

    logic [WIDTH-1:0] r_entry [QUEUE_DEPTH];
    logic [QPW-1:0]   r_wp,    n_wp;
    logic [QPW-1:0]   r_rp,    n_rp;
    logic [QCW-1:0]   r_count, n_count;

    assign o_valid = (r_count != '0);
    assign o_full  = (r_count == QCW'(QUEUE_DEPTH));
    assign o_data  = r_entry[r_rp];

    // Store the pushed word
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_entry[r_wp] <= i_data;
        end
    end

    // Advance pointers and occupancy
    always_comb begin
        n_wp    = r_wp;
        n_rp    = r_rp;
        n_count = r_count;
        if (i_push) begin
            n_wp = (r_wp == QPW'(QUEUE_DEPTH - 1)) ? '0 : r_wp + QPW'(1);
        end
        if (i_pop) begin
            n_rp = (r_rp == QPW'(QUEUE_DEPTH - 1)) ? '0 : r_rp + QPW'(1);
        end
        case ({i_push, i_pop})
            2'b10:   n_count = r_count + QCW'(1);
            2'b01:   n_count = r_count - QCW'(1);
            default: n_count = r_count;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp    <= '0;
            r_rp    <= '0;
            r_count <= '0;
        end else begin
            r_wp    <= n_wp;
            r_rp    <= n_rp;
            r_count <= n_count;
        end
    end

endmodule

[rtl/vtd_back.sv]
// ----------------------------------------------------------------------------
// vtd_back
// History engine: holds the ring of past frames, performs one write and one
// read per operation, and forms the result word in a registered output.
// ----------------------------------------------------------------------------
module vtd_back
    import vtd_pkg::*;
#(
    parameter int HISTORY_FRAMES = 64,
    parameter int FRAME_BYTES    = 65536
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_op_valid,
    input  t_op_info                   i_info,
    input  logic [$clog2(HISTORY_FRAMES)+$clog2(FRAME_BYTES)-1:0] i_wr_addr,
    input  logic [$clog2(HISTORY_FRAMES)+$clog2(FRAME_BYTES)-1:0] i_rd_addr,
    output logic                       o_pop,
    output logic                       o_out_valid,
    input  logic                       i_out_stall,
    output t_out_word                  o_out_word
);

    localparam int PW        = $clog2(FRAME_BYTES);
    localparam int MEM_DEPTH = HISTORY_FRAMES * (2 ** PW);

    logic [7:0] r_hist [MEM_DEPTH];
    logic [7:0] r_rd_data;
    logic       r_s1_valid;
    t_op_info   r_s1_info;
    logic       r_out_valid;
    t_out_word  r_out_word;
    logic       out_free;
    logic       s1_free;
    logic       s1_move;

    assign out_free = !r_out_valid || !i_out_stall;
    assign s1_move  = r_s1_valid && out_free;
    assign s1_free  = !r_s1_valid || out_free;
    assign o_pop    = i_op_valid && s1_free;

    // Store the byte and fetch the source byte in the same cycle
    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_hist[i_wr_addr] <= i_info.pixel_byte;
            r_rd_data         <= r_hist[i_rd_addr];
            r_s1_info         <= i_info;
        end
    end

    // Track the operation waiting on its read data
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (s1_free) begin
            r_s1_valid <= o_pop;
        end
    end

    // Form the result: own byte, zero when missing, else the history byte
    always_ff @(posedge i_clk) begin
        if (s1_move) begin
            if (r_s1_info.bypass) begin
                r_out_word.out_byte <= r_s1_info.pixel_byte;
            end else if (r_s1_info.missing) begin
                r_out_word.out_byte <= '0;
            end else begin
                r_out_word.out_byte <= r_rd_data;
            end
            r_out_word.source_missing <= r_s1_info.missing;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_free) begin
            r_out_valid <= s1_move;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out_word;

`ifndef SYNTH
    // Read data holds while its operation waits for the output register
    a_rd_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_s1_valid && !out_free |=> $stable(r_rd_data) && r_s1_valid)
        else $error("read data changed while waiting");

    // A delay of zero always has a source
    a_bypass_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_s1_valid |-> !(r_s1_info.bypass && r_s1_info.missing))
        else $error("bypass flagged as missing");

    // An operation leaving stage one lands in the output register
    a_s1_to_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s1_move |=> r_out_valid)
        else $error("operation lost between stage one and output");

    // No pop into a stage that cannot take it
    a_pop_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_pop && r_s1_valid |-> out_free)
        else $error("pop while stage one blocked");
`endif

endmodule

[rtl/video_time_displacement_top.sv]
// ----------------------------------------------------------------------------
// video_time_displacement_top
// Per-pixel frame delay: every byte goes into a ring of past frames and the
// byte at the same raster position from a chosen earlier frame comes out.
// ----------------------------------------------------------------------------
// Takes one word per clock and returns one result word per clock while the
// output is not stalled, via queue, stage one and output. The rate is set by
// the history memory, which takes one write and one read per word in the same
// cycle on separate ports; a two-entry queue parts the classifier from the
// memory engine. The history is not cleared after reset: a frame counts as
// captured only once written, and a frame length grown after capture may read
// stale bytes. Write i_cfg_wdata (bytes per frame, zero acts as one, values
// above FRAME_BYTES act as FRAME_BYTES) only while no word is in flight.
// ----------------------------------------------------------------------------
module video_time_displacement_top
    import vtd_pkg::*;
#(
    parameter int HISTORY_FRAMES = 64,
    parameter int FRAME_BYTES    = 65536
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_cfg_we,
    input  logic [CFG_W-1:0] i_cfg_wdata,
    input  logic             i_in_valid,
    output logic             o_in_stall,
    input  t_in_word         i_in_word,
    output logic             o_out_valid,
    input  logic             i_out_stall,
    output t_out_word        o_out_word
);

    localparam int AW = $clog2(HISTORY_FRAMES) + $clog2(FRAME_BYTES);
    localparam int QW = $bits(t_op_info) + 2 * AW;

    logic          push;
    logic          q_full;
    logic          q_valid;
    logic          pop;
    t_op_info      f_info;
    logic [AW-1:0] f_wr_addr;
    logic [AW-1:0] f_rd_addr;
    logic [QW-1:0] q_out;
    t_op_info      b_info;
    logic [AW-1:0] b_wr_addr;
    logic [AW-1:0] b_rd_addr;

    // Classify words and track the raster
    vtd_front #(
        .HISTORY_FRAMES(HISTORY_FRAMES),
        .FRAME_BYTES   (FRAME_BYTES)
    ) u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_wdata(i_cfg_wdata),
        .i_in_valid (i_in_valid),
        .i_in_word  (i_in_word),
        .i_q_full   (q_full),
        .o_in_stall (o_in_stall),
        .o_push     (push),
        .o_info     (f_info),
        .o_wr_addr  (f_wr_addr),
        .o_rd_addr  (f_rd_addr)
    );

    // Buffer classified operations
    vtd_queue #(
        .WIDTH(QW)
    ) u_queue (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_push (push),
        .i_data ({f_info, f_wr_addr, f_rd_addr}),
        .i_pop  (pop),
        .o_valid(q_valid),
        .o_full (q_full),
        .o_data (q_out)
    );

    assign {b_info, b_wr_addr, b_rd_addr} = q_out;

    // Access the history and drive results
    vtd_back #(
        .HISTORY_FRAMES(HISTORY_FRAMES),
        .FRAME_BYTES   (FRAME_BYTES)
    ) u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_op_valid (q_valid),
        .i_info     (b_info),
        .i_wr_addr  (b_wr_addr),
        .i_rd_addr  (b_rd_addr),
        .o_pop      (pop),
        .o_out_valid(o_out_valid),
        .i_out_stall(i_out_stall),
        .o_out_word (o_out_word)
    );

endmodule
